// ===== rtl/tfwq_pkg.sv =====
// ----------------------------------------------------------------------------
// tfwq_pkg
// shared constants and types of the tank full window qualifier
// ----------------------------------------------------------------------------
package tfwq_pkg;

  // default depth of the sample window
  localparam int unsigned TFWQ_WINDOW = 10;

  // configuration register indexes
  localparam logic [7:0] REG_FULL_THRESHOLD   = 8'd0;
  localparam logic [7:0] REG_BEEP_STREAK      = 8'd1;
  localparam logic [7:0] REG_MOTOR_OFF_STREAK = 8'd2;

  // register reset values
  localparam logic [3:0] FULL_THRESHOLD_RST   = 4'd4;
  localparam logic [7:0] BEEP_STREAK_RST      = 8'd4;
  localparam logic [7:0] MOTOR_OFF_STREAK_RST = 8'd5;

  // streak counter ceiling
  localparam logic [7:0] STREAK_MAX = 8'd255;

  // window update request
  typedef struct packed {
    logic push;     // a running tick stores its sample
    logic restart;  // first running tick: clear window before storing
    logic sample;   // raw sensor sample
  } tfwq_win_ctl_t;

endpackage

// ===== rtl/tfwq_window.sv =====
// ----------------------------------------------------------------------------
// tfwq_window
// circular window of the last WINDOW samples with a running full count
// ----------------------------------------------------------------------------
module tfwq_window #(
  parameter int unsigned WINDOW = tfwq_pkg::TFWQ_WINDOW,
  parameter int unsigned CNT_W  = $clog2(WINDOW + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tfwq_pkg::tfwq_win_ctl_t ctl,
  output logic [CNT_W-1:0]      count_cur,  // count held now
  output logic [CNT_W-1:0]      count_nxt   // count after this push
);
  import tfwq_pkg::*;

  localparam int unsigned PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW - 1);

  logic [WINDOW-1:0] window_r, window_nxt;
  logic [PTR_W-1:0]  ptr_r, ptr_nxt, ptr_use;
  logic [CNT_W-1:0]  count_r;
  logic              old_bit;

  always_comb begin
    window_nxt = window_r;
    ptr_nxt    = ptr_r;
    count_nxt  = count_r;
    ptr_use    = ctl.restart ? '0 : ptr_r;
    old_bit    = ctl.restart ? 1'b0 : window_r[ptr_use];
    if (ctl.push) begin
      if (ctl.restart) begin
        window_nxt = '0;
      end
      window_nxt[ptr_use] = ctl.sample;
      ptr_nxt   = (ptr_use == PTR_LAST) ? '0 : ptr_use + PTR_W'(1);
      count_nxt = (ctl.restart ? '0 : count_r) - CNT_W'(old_bit) + CNT_W'(ctl.sample);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
      ptr_r    <= '0;
      count_r  <= '0;
    end else begin
      window_r <= window_nxt;
      ptr_r    <= ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  assign count_cur = count_r;

endmodule

// ===== rtl/tank_full_window_qualifier.sv =====
// ----------------------------------------------------------------------------
// tank_full_window_qualifier
// qualifies a raw tank full sensor over a sliding window and drives beeper
// and motor off pulses from the streak of full ticks
// ----------------------------------------------------------------------------
// result: visible in the output register the cycle after its input is accepted
// throughput: one transaction per cycle unless a held result is not taken;
//   streak, output register and, if running, window update on an accepted tick
// reset: synchronous active low; window, streak, beeper and handshake state
//   clear, registers return to their defaults, no clearing pass
// ----------------------------------------------------------------------------
module tank_full_window_qualifier #(
  parameter int unsigned WINDOW = tfwq_pkg::TFWQ_WINDOW
) (
  input  logic       clk,
  input  logic       rst_n,
  // input ticks
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [0] motor_running, [1] level_full, rest zero
  // results
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [15:0] out_tdata, // [0] beep_on_pulse, [1] beep_off_pulse,
                                 // [2] motor_off_pulse, [3] beeper_active,
                                 // [7:4] window_full_count, [15:8] full_streak
  // configuration writes
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_addr,
  input  logic [7:0] cfg_data
);
  import tfwq_pkg::*;

  localparam int unsigned CNT_W = $clog2(WINDOW + 1);
  localparam int unsigned CMP_W = (CNT_W > 4) ? CNT_W : 4;

  // configuration registers
  logic [3:0] full_threshold_r;
  logic [7:0] beep_streak_r;
  logic [7:0] motor_off_streak_r;

  // tick state
  logic [7:0] streak_r, streak_nxt;
  logic       beeping_r, beeping_nxt;
  logic       was_running_r, was_running_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_data_r, out_data_nxt;

  logic          in_accept;
  logic          running, sample;
  tfwq_win_ctl_t win_ctl;
  logic [CNT_W-1:0] count_cur, count_nxt, count;
  logic [7:0]    streak_base;
  logic          over_thr, rose;
  logic          beep_on, beep_clr, stop_req;
  logic [3:0]    count_out;

  // output register frees up when its result is taken
  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign running = in_tdata[0];
  assign sample  = in_tdata[1];

  assign win_ctl.push    = in_accept && running;
  assign win_ctl.restart = !was_running_r;
  assign win_ctl.sample  = sample;

  tfwq_window #(
    .WINDOW (WINDOW),
    .CNT_W  (CNT_W)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (win_ctl),
    .count_cur (count_cur),
    .count_nxt (count_nxt)
  );

  always_comb begin
    count       = running ? count_nxt : count_cur;
    // motor start restarts the streak
    streak_base = was_running_r ? streak_r : '0;
    over_thr    = CMP_W'(count) >= CMP_W'(full_threshold_r);
    rose        = running && over_thr && (streak_base != STREAK_MAX);

    streak_nxt = streak_r;
    if (running) begin
      if (!over_thr) begin
        streak_nxt = '0;
      end else if (rose) begin
        streak_nxt = streak_base + 8'd1;
      end else begin
        streak_nxt = streak_base;
      end
    end

    // beep on and motor off pulses only on a tick that actually raised the streak
    beep_on  = rose && (beep_streak_r != '0) && (streak_nxt == beep_streak_r);
    stop_req = rose && (motor_off_streak_r != '0) && (streak_nxt == motor_off_streak_r);
    beep_clr = !running && beeping_r;

    beeping_nxt     = running ? (beeping_r || beep_on) : 1'b0;
    was_running_nxt = running;

    // count saturates at the field width
    count_out = (CMP_W'(count) > CMP_W'(15)) ? 4'd15 : 4'(count);

    out_data_nxt  = {streak_nxt, count_out, beeping_nxt, stop_req, beep_clr, beep_on};
    out_valid_nxt = in_accept || (out_valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      streak_r      <= '0;
      beeping_r     <= 1'b0;
      was_running_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_accept) begin
        streak_r      <= streak_nxt;
        beeping_r     <= beeping_nxt;
        was_running_r <= was_running_nxt;
      end
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  // register file; out of range writes fall through
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_threshold_r   <= FULL_THRESHOLD_RST;
      beep_streak_r      <= BEEP_STREAK_RST;
      motor_off_streak_r <= MOTOR_OFF_STREAK_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_addr)
        REG_FULL_THRESHOLD:   full_threshold_r   <= cfg_data[3:0];
        REG_BEEP_STREAK:      beep_streak_r      <= cfg_data;
        REG_MOTOR_OFF_STREAK: motor_off_streak_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
